// File: hw/rtl/pss_pkg.sv
`default_nettype none
package pss_pkg;
    localparam int MAX_PROCS_DEF = 16;
    localparam int TIME_W = 16;
    localparam int PRIO_W = 8;
    localparam int ID_W = 4;
    localparam int RESULT_LIMIT = 16;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_RR   = 2'd1;
    localparam logic [1:0] MODE_PRIO = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_SLICE = 1'b1;

    localparam logic FUNC_LOAD = 1'b0;

    // command broadcast into the cell row
    typedef struct packed {
        logic                load;    // write entry at load_sel
        logic                charge;  // charge entry at sel
        logic [TIME_W-1:0]   sub;     // ticks taken off remaining
        logic [TIME_W-1:0]   add;     // ticks added to used
        logic [PRIO_W-1:0]   prio;
        logic [TIME_W-1:0]   need;
    } pss_cmd_t;

    // per-cell view handed to the controller
    typedef struct packed {
        logic                live;    // loaded and unfinished
        logic [PRIO_W-1:0]   prio;
        logic [TIME_W-1:0]   remain;
        logic [TIME_W-1:0]   used;
    } pss_view_t;
endpackage
`default_nettype wire

// File: hw/rtl/pss_cell.sv
`default_nettype none
module pss_cell
    import pss_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      sel,
    input  wire logic      load_sel,
    input  pss_cmd_t       cmd,
    output pss_view_t      view
);
    logic              loaded_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [TIME_W-1:0] remain_reg;
    logic [TIME_W-1:0] used_reg;
    logic [TIME_W:0]   sum;

    assign sum = {1'b0, used_reg} + {1'b0, cmd.add};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            loaded_reg <= 1'b0;
        else if (cmd.load && load_sel)
            loaded_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_sel)
        begin
            prio_reg   <= cmd.prio;
            remain_reg <= cmd.need;
            used_reg   <= '0;
        end
        else if (cmd.charge && sel)
        begin
            remain_reg <= (remain_reg > cmd.sub) ? remain_reg - cmd.sub : '0;
            used_reg   <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end
    end

    assign view.live   = loaded_reg && (remain_reg != '0);
    assign view.prio   = prio_reg;
    assign view.remain = remain_reg;
    assign view.used   = used_reg;
endmodule
`default_nettype wire

// File: hw/rtl/pss_scan.sv
`default_nettype none
// One scan stage: compares the running best against one cell each cycle.
module pss_scan
    import pss_pkg::*;
#(
    parameter int N = MAX_PROCS_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [1:0]            mode,
    input  wire logic [$clog2(N)-1:0]  first,
    input  wire pss_view_t             views [N],
    output logic                       busy,
    output logic                       found,
    output logic [$clog2(N)-1:0]       best
);
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     best_reg, best_next;
    logic              take;

    assign busy  = (cnt_reg != '0);
    assign found = found_reg;
    assign best  = best_reg;

    always_comb
    begin
        take = views[idx_reg].live &&
               (!found_reg || (mode == MODE_PRIO &&
                               views[idx_reg].prio > views[best_reg].prio));
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        best_next  = best_reg;
        if (start)
        begin
            cnt_next   = CW'(N);
            idx_next   = first;
            found_next = 1'b0;
            best_next  = first;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            idx_next = (idx_reg == IW'(N - 1)) ? '0 : idx_reg + 1'b1;
            if (take)
            begin
                found_next = 1'b1;
                best_next  = idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            best_reg  <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            best_reg  <= best_next;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/process_slice_scheduler.sv
`default_nettype none
// Process slice scheduler.
// s_axis beat: tdata = {need_time, prio_value}, tuser = func (1 runs a round,
// 0 loads a process). m_axis beat: tdata = {status, all_done, proc_done,
// left_time, used_time, proc_id}, tlast marks the final result of an input.
// cfg_we/cfg_addr/cfg_wdata write sched_mode (0) and slice_length (1); the user
// must write them only while idle, as the block does not enforce it. Processes
// live in a row of cells, one per table entry. A load result passes through
// load_reg into the output register. A round scans the row one cell per cycle
// and then charges the chosen cell; a priority round gives up to 16 results,
// each needing its own scan, run while the previous result waits in the
// output register. One input is processed at a time; s_tready is low while a
// result waits, so a stalled receiver holds the block.
// Reset empties the table, clears pointers, sets mode 0 and slice 1.
module process_slice_scheduler
    import pss_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // prio_value[7:0], need_time[23:8]
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // proc_id, used_time, left_time,
                                        // proc_done, all_done, status
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);
    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WAIT  = 5'b00100,
        S_CHG   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        mode_reg;
    logic [7:0]        slice_reg;
    logic [CW-1:0]     count_reg;
    logic [IW-1:0]     rr_reg;
    logic [CW-1:0]     fcfs_reg;
    logic [TIME_W-1:0] ticks_reg;
    logic [4:0]        nres_reg;
    logic [IW-1:0]     cur_reg;
    logic              load_reg;
    logic              full_reg;
    logic              out_v_reg;
    logic              out_last_reg;
    logic [39:0]       out_data_reg;
    logic              pend_empty_reg;

    pss_cmd_t          cmd;
    pss_view_t         views [MAX_PROCS];
    logic [MAX_PROCS-1:0] live_vec;
    logic              any_live;
    logic              scan_start, scan_busy, scan_found;
    logic [IW-1:0]     scan_best, scan_first;
    logic [TIME_W-1:0] run_amt;
    logic              accept;
    logic              out_set;
    logic [1:0]        res_st;
    logic              res_ok;
    logic [39:0]       res_data;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !out_v_reg && !load_reg && !pend_empty_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_PROCS; g++)
        begin : g_cell
            pss_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .sel      (cur_reg == IW'(g)),
                .load_sel (count_reg == CW'(g)),
                .cmd      (cmd),
                .view     (views[g])
            );
            assign live_vec[g] = views[g].live;
        end
    endgenerate
    assign any_live = |live_vec;

    assign scan_first = (mode_reg == MODE_RR) ? rr_reg :
                        (mode_reg == MODE_PRIO) ? '0 :
                        (fcfs_reg < CW'(MAX_PROCS)) ? fcfs_reg[IW-1:0] : '0;

    pss_scan #(.N(MAX_PROCS)) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .mode  (mode_reg),
        .first (scan_first),
        .views (views),
        .busy  (scan_busy),
        .found (scan_found),
        .best  (scan_best)
    );

    always_comb
    begin
        if (mode_reg == MODE_RR)
            run_amt = ticks_reg;
        else if (mode_reg == MODE_PRIO)
            run_amt = (views[cur_reg].remain < ticks_reg) ?
                      views[cur_reg].remain : ticks_reg;
        else
            run_amt = views[cur_reg].remain;
    end

    always_comb
    begin
        cmd.load   = accept && (s_tuser == FUNC_LOAD) &&
                     (count_reg < CW'(MAX_PROCS));
        cmd.charge = (state_reg == S_CHG);
        cmd.sub    = run_amt;
        cmd.add    = run_amt;
        cmd.prio   = s_tdata[7:0];
        cmd.need   = s_tdata[23:8];
    end

    assign scan_start = (state_reg == S_SCAN);

    // another priority result follows once this one is delivered
    function automatic logic out_last_reg_n();
        return (mode_reg == MODE_PRIO) && (ticks_reg != '0) &&
               any_live && (nres_reg < 5'(RESULT_LIMIT));
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept && s_tuser != FUNC_LOAD && any_live)
                         state_next = S_SCAN;
            S_SCAN:  state_next = S_WAIT;
            S_WAIT:  if (!scan_busy) state_next = S_CHG;
            S_CHG:   state_next = S_OUT;
            S_OUT:
            begin
                if (!out_v_reg || m_tready)
                begin
                    if (!out_last_reg_n()) state_next = S_IDLE;
                    else state_next = S_SCAN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // capture the result beat so it holds while the next scan runs
    assign out_set  = load_reg || pend_empty_reg ||
                      (state_reg == S_OUT && (!out_v_reg || m_tready));
    assign res_st   = load_reg ? (full_reg ? ST_FULL : ST_OK) :
                      pend_empty_reg ? ST_EMPTY : ST_OK;
    assign res_ok   = (res_st == ST_OK);
    assign res_data = {res_st, ~any_live,
                       res_ok & ~views[cur_reg].live,
                       res_ok ? views[cur_reg].remain : 16'd0,
                       res_ok ? views[cur_reg].used : 16'd0,
                       res_ok ? 4'(cur_reg) : 4'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_FCFS;
            slice_reg      <= 8'd1;
            count_reg      <= '0;
            rr_reg         <= '0;
            fcfs_reg       <= '0;
            ticks_reg      <= '0;
            nres_reg       <= '0;
            cur_reg        <= '0;
            load_reg       <= 1'b0;
            full_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
            out_last_reg   <= 1'b0;
            out_data_reg   <= '0;
            pend_empty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_addr == CFG_MODE)  mode_reg  <= cfg_wdata[1:0];
            if (cfg_we && cfg_addr == CFG_SLICE) slice_reg <= cfg_wdata;
            // load and empty-round results are staged in load_reg/pend_empty_reg
            load_reg       <= accept && (s_tuser == FUNC_LOAD);
            pend_empty_reg <= accept && (s_tuser != FUNC_LOAD) && !any_live;
            if (accept)
            begin
                ticks_reg <= {8'd0, (slice_reg == 8'd0) ? 8'd1 : slice_reg};
                nres_reg  <= '0;
                if (s_tuser == FUNC_LOAD)
                begin
                    full_reg <= !(count_reg < CW'(MAX_PROCS));
                    cur_reg  <= count_reg[IW-1:0];
                    if (count_reg < CW'(MAX_PROCS)) count_reg <= count_reg + 1'b1;
                end
            end
            if (out_set)
            begin
                out_v_reg    <= 1'b1;
                out_last_reg <= (load_reg || pend_empty_reg) ? 1'b1 : !out_last_reg_n();
                out_data_reg <= res_data;
            end
            else if (m_tvalid && m_tready)
                out_v_reg <= 1'b0;
            if (state_reg == S_WAIT && !scan_busy && scan_found)
                cur_reg <= scan_best;
            if (state_reg == S_CHG)
            begin
                ticks_reg <= (mode_reg == MODE_PRIO) ? ticks_reg - run_amt : ticks_reg;
                nres_reg  <= nres_reg + 1'b1;
                if (mode_reg == MODE_RR)
                    rr_reg <= (cur_reg == IW'(MAX_PROCS - 1)) ? '0 : cur_reg + 1'b1;
                if (mode_reg != MODE_RR && mode_reg != MODE_PRIO)
                    fcfs_reg <= CW'(cur_reg) + 1'b1;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = out_data_reg;
endmodule
`default_nettype wire

// File: hw/rtl/pss_checker.sv
`default_nettype none
module pss_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[39:38] != 2'd0 |-> m_tlast)
        else $error("error result not last");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[39:38] == 2'd2 |-> m_tdata[37])
        else $error("empty round without all_done");
endmodule

bind process_slice_scheduler pss_checker u_pss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none
module testbench;
    import pss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       FUNC_STEP  = 1'b1;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         NPROC      = 16;
    localparam int         IDLE_LIMIT = 3000;

    typedef struct {
        logic [3:0]  proc_id;
        logic [15:0] used_time;
        logic [15:0] left_time;
        logic        proc_done;
        logic        all_done;
        logic [1:0]  status;
        logic        last;
    } sched_result_t;

    class sched_scoreboard;
        logic [7:0]    prio_q[NPROC];
        logic [15:0]   remain_q[NPROC];
        logic [15:0]   used_q[NPROC];
        int            loaded;
        int            rr_next;
        int            fcfs_next;
        logic [1:0]    mode;
        logic [7:0]    slice;
        sched_result_t pending[$];
        int            errors;
        int            checked;

        function new();
            loaded = 0;
            rr_next = 0;
            fcfs_next = 0;
            mode = MODE_FCFS;
            slice = 8'd1;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic addr, logic [7:0] val);
            if (addr == CFG_MODE)
                mode = val[1:0];
            else
                slice = val;
        endfunction

        function bit all_finished();
            for (int i = 0; i < loaded; i++)
                if (remain_q[i] != 0)
                    return 0;
            return 1;
        endfunction

        function void push(int id, logic [15:0] u, logic [15:0] l, logic d, logic a,
                           logic [1:0] st);
            sched_result_t r;
            r.proc_id = id[3:0];
            r.used_time = u;
            r.left_time = l;
            r.proc_done = d;
            r.all_done = a;
            r.status = st;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void push_proc(int i);
            push(i, used_q[i], remain_q[i], remain_q[i] == 0, all_finished(), ST_OK);
        endfunction

        function logic [15:0] sat_sum(logic [15:0] a, int b);
            int s;
            s = a + b;
            return s > 65535 ? 16'hFFFF : s[15:0];
        endfunction

        function void note_input(logic func, logic [7:0] prio, logic [15:0] need);
            int ticks;
            int i;
            int n;
            int best;
            int run;
            bit found;
            ticks = (slice == 0) ? 1 : slice;
            if (func == FUNC_LOAD) begin
                if (loaded >= NPROC) begin
                    push(0, 0, 0, 0, all_finished(), ST_FULL);
                end else begin
                    prio_q[loaded] = prio;
                    remain_q[loaded] = need;
                    used_q[loaded] = 0;
                    loaded++;
                    push_proc(loaded - 1);
                end
            end else if (all_finished()) begin
                push(0, 0, 0, 0, 1, ST_EMPTY);
            end else if (mode == MODE_RR) begin
                i = 0;
                for (int k = 0; k < NPROC; k++) begin
                    i = (rr_next + k) % NPROC;
                    if (i < loaded && remain_q[i] != 0)
                        break;
                end
                remain_q[i] = (remain_q[i] > ticks) ? 16'(remain_q[i] - ticks) : 16'd0;
                used_q[i] = sat_sum(used_q[i], ticks);
                rr_next = (i + 1) % NPROC;
                push_proc(i);
            end else if (mode == MODE_PRIO) begin
                n = 0;
                while (ticks > 0 && n < RESULT_LIMIT) begin
                    found = 0;
                    best = 0;
                    for (int j = 0; j < loaded; j++) begin
                        if (remain_q[j] == 0)
                            continue;
                        if (!found || prio_q[j] > prio_q[best]) begin
                            best = j;
                            found = 1;
                        end
                    end
                    if (!found)
                        break;
                    run = (remain_q[best] < ticks) ? int'(remain_q[best]) : ticks;
                    remain_q[best] = remain_q[best] - 16'(run);
                    used_q[best] = sat_sum(used_q[best], run);
                    ticks -= run;
                    push_proc(best);
                    n++;
                end
            end else begin
                // first come, first served; the spare mode lands here too
                i = (fcfs_next < NPROC) ? fcfs_next : 0;
                while (i < loaded && remain_q[i] == 0)
                    i++;
                if (i >= loaded) begin
                    for (i = 0; i < loaded; i++)
                        if (remain_q[i] != 0)
                            break;
                end
                used_q[i] = sat_sum(used_q[i], int'(remain_q[i]));
                remain_q[i] = 0;
                fcfs_next = i + 1;
                push_proc(i);
            end
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [39:0] data, logic tlast);
            sched_result_t e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: data=%h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (data[3:0] !== e.proc_id) begin
                $error("proc_id expected %0d actual %0d", e.proc_id, data[3:0]);
                errors++;
            end
            if (data[19:4] !== e.used_time) begin
                $error("used_time expected %0d actual %0d", e.used_time, data[19:4]);
                errors++;
            end
            if (data[35:20] !== e.left_time) begin
                $error("left_time expected %0d actual %0d", e.left_time, data[35:20]);
                errors++;
            end
            if (data[36] !== e.proc_done) begin
                $error("proc_done expected %0d actual %0d", e.proc_done, data[36]);
                errors++;
            end
            if (data[37] !== e.all_done) begin
                $error("all_done expected %0d actual %0d", e.all_done, data[37]);
                errors++;
            end
            if (data[39:38] !== e.status) begin
                $error("status expected %0d actual %0d", e.status, data[39:38]);
                errors++;
            end
            if (tlast !== e.last) begin
                $error("last expected %0d actual %0d", e.last, tlast);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // prio_value[7:0], need_time[23:8]
    logic        s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // proc_id, used_time, left_time, proc_done, all_done, status
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_addr;
    logic [7:0]  cfg_wdata;

    sched_scoreboard sb;
    int burst_left;
    int stall_left;
    bit rx_calm;
    int idle_cycles;
    int n_loads;
    int n_rounds;

    process_slice_scheduler uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stalls on its own pattern
    always @(posedge clk)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send(logic func, logic [7:0] prio, logic [15:0] need);
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {need, prio};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(func, prio, need);
        if (func == FUNC_LOAD)
            n_loads++;
        else
            n_rounds++;
        // end of burst: at random, drop valid for a random gap
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 1)) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic addr, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(addr, val);
    endtask

    task automatic step_round();
        send(FUNC_STEP, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        logic [1:0] m;
        logic [7:0] sl;
        logic [15:0] need;
        sb = new();
        burst_left = 0;
        stall_left = 0;
        rx_calm = 0;
        idle_cycles = 0;
        n_loads = 0;
        n_rounds = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_MODE;
        cfg_wdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, zero need, every mode
        step_round();
        send(FUNC_LOAD, 8'd0, 16'd0);
        step_round();
        send(FUNC_LOAD, 8'd255, 16'hFFFF);
        send(FUNC_LOAD, 8'd128, 16'd1);
        send(FUNC_LOAD, 8'd128, 16'd300);
        step_round();
        settle();
        write_reg(CFG_MODE, 8'(MODE_RR));
        write_reg(CFG_SLICE, 8'd255);
        repeat (3) step_round();
        settle();
        write_reg(CFG_SLICE, 8'd0);
        repeat (2) step_round();
        settle();
        write_reg(CFG_MODE, 8'(MODE_PRIO));
        write_reg(CFG_SLICE, 8'd255);
        send(FUNC_LOAD, 8'd7, 16'd2);
        send(FUNC_LOAD, 8'd7, 16'd3);
        repeat (3) step_round();
        settle();
        write_reg(CFG_MODE, 8'(MODE_SPARE));
        repeat (2) step_round();
        settle();

        // random phases; table fills for good, so most work is rounds
        for (int ph = 0; ph < 12; ph++) begin
            m = 2'($urandom_range(0, 3));
            case (ph)
                0: sl = 8'd1;
                1: sl = 8'd255;
                default: sl = 8'($urandom_range(1, 255));
            endcase
            write_reg(CFG_MODE, 8'(m));
            write_reg(CFG_SLICE, sl);
            rx_calm = (ph % 4 == 3);
            for (int k = 0; k < 30; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    need = $urandom_range(0, 1) ? 16'($urandom_range(0, 40))
                                                : 16'($urandom_range(0, 65535));
                    send(FUNC_LOAD, 8'($urandom_range(0, 255)), need);
                end else begin
                    step_round();
                end
            end
            settle();
        end

        $display("covered %0d loads and %0d scheduling rounds, %0d result beats checked",
                 n_loads, n_rounds, sb.checked);
        $display("modes FCFS/RR/PRIO/spare with slices from 0 to 255 under random stalls");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
